// ===== hw/rtl/tfr_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Telemetry frame receiver package
// Shared constants, codes, beat types and the binary frame field layout.
// ----------------------------------------------------------------------------
package tfr_pkg;

  // Default payload length of a binary frame, in bytes.
  localparam int PAYLOAD_BYTES_DEF = 54;

  // Binary frame layout.
  localparam int FLOAT_COUNT = 8;
  localparam int FLAG_COUNT  = 16;
  localparam int NUM_FIELDS  = FLOAT_COUNT + 4;
  localparam int FLD_W       = $clog2(NUM_FIELDS);
  localparam logic [63:0] FLAG_MASK = (64'd1 << FLAG_COUNT) - 64'd1;

  // Frame type bytes.
  localparam logic [7:0] TYPE_BINARY = 8'h01;
  localparam logic [7:0] TYPE_TEXT   = 8'h02;

  // Result kind codes.
  localparam logic [2:0] KIND_TEXT_CHAR  = 3'd0;
  localparam logic [2:0] KIND_PKT_COUNT  = 3'd1;
  localparam logic [2:0] KIND_FLOAT_BITS = 3'd2;
  localparam logic [2:0] KIND_FLAG_MASK  = 3'd3;
  localparam logic [2:0] KIND_DOUBLE     = 3'd4;
  localparam logic [2:0] KIND_CSUM_ERR   = 3'd5;
  localparam logic [2:0] KIND_EMPTY_TEXT = 3'd6;

  // Configuration register indexes.
  localparam logic REG_SYNC_FIRST  = 1'b0;
  localparam logic REG_SYNC_SECOND = 1'b1;

  // Result produced directly by the byte parser (one byte wide value).
  typedef struct packed {
    logic       valid;
    logic [2:0] kind;
    logic [4:0] idx;
    logic [7:0] value;
    logic       last;
  } prs_result_t;

  // Result produced by the field emitter.
  typedef struct packed {
    logic        valid;
    logic [2:0]  kind;
    logic [4:0]  idx;
    logic [63:0] value;
    logic        last;
  } emit_result_t;

  // Payload store write request.
  typedef struct packed {
    logic       en;
    logic [7:0] addr;
    logic [7:0] data;
  } mem_wr_t;

  // Description of one field of a good binary frame.
  typedef struct packed {
    logic [2:0] kind;
    logic [4:0] idx;
    logic [3:0] nbytes;
    logic       last;
  } field_desc_t;

  function automatic field_desc_t field_desc(input logic [FLD_W-1:0] fld);
    field_desc_t d;
    int          f;
    f        = int'(fld);
    d.kind   = KIND_DOUBLE;
    d.idx    = 5'd0;
    d.nbytes = 4'd8;
    d.last   = 1'b0;
    if (f == 0) begin
      d.kind   = KIND_PKT_COUNT;
      d.nbytes = 4'd4;
    end else if (f <= FLOAT_COUNT) begin
      d.kind   = KIND_FLOAT_BITS;
      d.idx    = 5'(f - 1);
      d.nbytes = 4'd4;
    end else if (f == FLOAT_COUNT + 1) begin
      d.kind   = KIND_FLAG_MASK;
      d.nbytes = 4'd2;
    end else begin
      d.idx  = 5'(f - FLOAT_COUNT - 2);
      d.last = (f == FLOAT_COUNT + 3);
    end
    return d;
  endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/tfr_byte_parser.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Telemetry frame byte parser
// Header hunt, type decode, payload capture with running XOR, text streaming.
// ----------------------------------------------------------------------------
module tfr_byte_parser
  import tfr_pkg::*;
#(
  parameter int PAYLOAD_BYTES = PAYLOAD_BYTES_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic [7:0]  sync_first,
  input  wire logic [7:0]  sync_second,
  input  wire logic        in_fire,
  input  wire logic [7:0]  in_byte,
  output logic             may_result,
  output prs_result_t      res,
  output mem_wr_t          wr,
  output logic             emit_start
);

  typedef enum logic [2:0] {
    PH_HUNT1, PH_HUNT2, PH_TYPE, PH_BODY, PH_TEXT, PH_CHECK
  } phase_t;

  phase_t     phase_r, phase_nxt;
  logic [7:0] frame_kind_r, frame_kind_nxt;
  logic [7:0] byte_count_r, byte_count_nxt;
  logic [7:0] text_length_r, text_length_nxt;
  logic [7:0] running_xor_r, running_xor_nxt;
  logic [8:0] count_inc;

  assign count_inc = {1'b0, byte_count_r} + 9'd1;

  // A byte in these phases can produce a result beat.
  assign may_result = (phase_r == PH_TEXT) || (phase_r == PH_CHECK) ||
                      ((phase_r == PH_BODY) && (frame_kind_r == TYPE_TEXT));

  always_comb begin
    phase_nxt       = phase_r;
    frame_kind_nxt  = frame_kind_r;
    byte_count_nxt  = byte_count_r;
    text_length_nxt = text_length_r;
    running_xor_nxt = running_xor_r;
    res             = '0;
    wr              = '0;
    emit_start      = 1'b0;
    if (in_fire) begin
      case (phase_r)
        PH_HUNT2: begin
          phase_nxt = (in_byte == sync_second) ? PH_TYPE : PH_HUNT1;
        end
        PH_TYPE: begin
          frame_kind_nxt  = in_byte;
          byte_count_nxt  = 8'd0;
          running_xor_nxt = 8'd0;
          phase_nxt       = PH_BODY;
        end
        PH_BODY: begin
          if (frame_kind_r == TYPE_BINARY) begin
            wr.en           = (9'({1'b0, byte_count_r}) < 9'(PAYLOAD_BYTES));
            wr.addr         = byte_count_r;
            wr.data         = in_byte;
            running_xor_nxt = running_xor_r ^ in_byte;
            byte_count_nxt  = count_inc[7:0];
            if (count_inc >= 9'(PAYLOAD_BYTES)) begin
              phase_nxt = PH_CHECK;
            end
          end else if (frame_kind_r == TYPE_TEXT) begin
            text_length_nxt = in_byte;
            byte_count_nxt  = 8'd0;
            if (in_byte == 8'd0) begin
              phase_nxt = PH_HUNT1;
              res.valid = 1'b1;
              res.kind  = KIND_EMPTY_TEXT;
              res.last  = 1'b1;
            end else begin
              phase_nxt = PH_TEXT;
            end
          end else begin
            // Unknown type: this byte is dropped.
            phase_nxt = PH_HUNT1;
          end
        end
        PH_TEXT: begin
          byte_count_nxt = count_inc[7:0];
          res.valid      = 1'b1;
          res.kind       = KIND_TEXT_CHAR;
          res.idx        = byte_count_r[4:0];
          res.value      = in_byte;
          res.last       = (count_inc[7:0] == text_length_r);
          if (res.last) begin
            phase_nxt = PH_HUNT1;
          end
        end
        PH_CHECK: begin
          phase_nxt = PH_HUNT1;
          if (running_xor_r != in_byte) begin
            res.valid = 1'b1;
            res.kind  = KIND_CSUM_ERR;
            res.value = running_xor_r;
            res.last  = 1'b1;
          end else begin
            emit_start = 1'b1;
          end
        end
        default: begin
          phase_nxt = (in_byte == sync_first) ? PH_HUNT2 : PH_HUNT1;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r       <= PH_HUNT1;
      frame_kind_r  <= 8'd0;
      byte_count_r  <= 8'd0;
      text_length_r <= 8'd0;
      running_xor_r <= 8'd0;
    end else begin
      phase_r       <= phase_nxt;
      frame_kind_r  <= frame_kind_nxt;
      byte_count_r  <= byte_count_nxt;
      text_length_r <= text_length_nxt;
      running_xor_r <= running_xor_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/tfr_field_emit.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Telemetry frame field emitter
// Payload store, and a byte-serial sequencer that assembles the frame fields.
// ----------------------------------------------------------------------------
module tfr_field_emit
  import tfr_pkg::*;
#(
  parameter int PAYLOAD_BYTES = PAYLOAD_BYTES_DEF
) (
  input  wire logic   clk,
  input  wire logic   rst_n,
  input  wire mem_wr_t wr,
  input  wire logic   start,
  input  wire logic   out_free,
  output logic        busy,
  output emit_result_t res
);

  localparam int AW = $clog2(PAYLOAD_BYTES);

  typedef enum logic [1:0] {E_IDLE, E_RD, E_SH, E_LOAD} est_t;

  logic [7:0]       mem_r [PAYLOAD_BYTES];
  logic [7:0]       rd_data_r;
  logic [AW-1:0]    rd_addr;
  logic             pos_in_range;

  est_t             state_r, state_nxt;
  logic [FLD_W-1:0] fld_r, fld_nxt;
  logic [2:0]       bsel_r, bsel_nxt;
  logic [7:0]       pos_r, pos_nxt;
  logic [63:0]      value_r, value_nxt;
  field_desc_t      desc;
  logic [7:0]       byte_in;

  assign pos_in_range = (9'({1'b0, pos_r}) < 9'(PAYLOAD_BYTES));
  assign rd_addr      = pos_in_range ? pos_r[AW-1:0] : '0;
  assign byte_in      = pos_in_range ? rd_data_r : 8'd0;
  assign desc         = field_desc(fld_r);
  assign busy         = (state_r != E_IDLE);

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem_r[wr.addr[AW-1:0]] <= wr.data;
    end
    rd_data_r <= mem_r[rd_addr];
  end

  always_comb begin
    state_nxt = state_r;
    fld_nxt   = fld_r;
    bsel_nxt  = bsel_r;
    pos_nxt   = pos_r;
    value_nxt = value_r;
    res       = '0;
    case (state_r)
      E_IDLE: begin
        if (start) begin
          state_nxt = E_RD;
          fld_nxt   = '0;
          bsel_nxt  = 3'd0;
          pos_nxt   = 8'd0;
          value_nxt = '0;
        end
      end
      E_RD: begin
        // Read data for pos_r lands in rd_data_r at this edge.
        state_nxt = E_SH;
      end
      E_SH: begin
        value_nxt[{bsel_r, 3'b000} +: 8] = byte_in;
        pos_nxt = pos_r + 8'd1;
        if ({1'b0, bsel_r} == desc.nbytes - 4'd1) begin
          state_nxt = E_LOAD;
        end else begin
          bsel_nxt  = bsel_r + 3'd1;
          state_nxt = E_RD;
        end
      end
      E_LOAD: begin
        if (out_free) begin
          res.valid = 1'b1;
          res.kind  = desc.kind;
          res.idx   = desc.idx;
          res.value = (desc.kind == KIND_FLAG_MASK) ? (value_r & FLAG_MASK) : value_r;
          res.last  = desc.last;
          if (desc.last) begin
            state_nxt = E_IDLE;
          end else begin
            fld_nxt   = fld_r + 1'b1;
            bsel_nxt  = 3'd0;
            value_nxt = '0;
            state_nxt = E_RD;
          end
        end
      end
      default: begin
        state_nxt = E_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= E_IDLE;
      fld_r   <= '0;
      bsel_r  <= 3'd0;
      pos_r   <= 8'd0;
    end else begin
      state_r <= state_nxt;
      fld_r   <= fld_nxt;
      bsel_r  <= bsel_nxt;
      pos_r   <= pos_nxt;
    end
    value_r <= value_nxt;
  end

endmodule
`default_nettype wire

// ===== hw/rtl/telemetry_frame_receiver_core.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Telemetry frame receiver core
// Parses sync-headed binary and text telemetry frames from a byte stream.
// ----------------------------------------------------------------------------
// Usage:
// The in_ stream carries one received byte per beat. The parser hunts for the
// two header bytes held in the configuration registers, reads the type byte,
// then either captures a binary payload or streams a text frame.
// Each out_ beat carries one result: kind, item_index and a 64-bit value in
// tdata, and tlast on the final beat of a frame.
// A byte that produces no result is taken back to back while the unpacking
// sequencer is idle. A text character or an error beat is loaded into the
// output register at the edge that takes the byte and shows in the next
// cycle; the next such byte waits until that beat has left the register.
// A good binary frame is unpacked byte by byte from the payload
// memory: each payload byte passes a read state and a shift state, and each
// field then a load state that hands its beat to the output register. The
// input stays stalled while that unpacking runs.
// A new byte is taken while a result waits in the output register, unless
// that byte could itself produce a result. A stalled receiver therefore holds
// the parser and the unpacking sequencer, and no beat is lost.
// Reset returns the parser to header hunting and the sync registers to 0xAA
// and 0x55. The payload memory is not cleared.
// ----------------------------------------------------------------------------
module telemetry_frame_receiver_core
  import tfr_pkg::*;
#(
  parameter int PAYLOAD_BYTES = PAYLOAD_BYTES_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // Input stream
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,   // [7:0] rx_byte
  // Result stream
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [71:0]      out_tdata,  // [2:0] kind, [7:3] item_index, [71:8] value
  output logic             out_tlast,  // last
  // Configuration port
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [2:0]  cfg_paddr,
  input  wire logic [31:0] cfg_pwdata,
  output logic [31:0]      cfg_prdata,
  output logic             cfg_pready
);

  logic [7:0]   sync_first_r, sync_first_nxt;
  logic [7:0]   sync_second_r, sync_second_nxt;
  logic         cfg_wr;
  logic         cfg_sel;

  logic         in_fire;
  logic         out_free;
  logic         may_result;
  logic         emit_busy;
  logic         emit_start;
  prs_result_t  prs_res;
  emit_result_t emit_res;
  mem_wr_t      mem_wr;

  logic         out_valid_r, out_valid_nxt;
  logic [2:0]   out_kind_r, out_kind_nxt;
  logic [4:0]   out_idx_r, out_idx_nxt;
  logic [63:0]  out_value_r, out_value_nxt;
  logic         out_last_r, out_last_nxt;

  // Configuration registers: register index is address bit 2.
  assign cfg_pready = 1'b1;
  assign cfg_sel    = cfg_paddr[2];
  assign cfg_wr     = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;
  assign cfg_prdata = (cfg_sel == REG_SYNC_SECOND) ? {24'd0, sync_second_r}
                                                   : {24'd0, sync_first_r};

  always_comb begin
    sync_first_nxt  = sync_first_r;
    sync_second_nxt = sync_second_r;
    if (cfg_wr) begin
      if (cfg_sel == REG_SYNC_FIRST) begin
        sync_first_nxt = cfg_pwdata[7:0];
      end else begin
        sync_second_nxt = cfg_pwdata[7:0];
      end
    end
  end

  // Input handshake: the unpacking sequencer owns the output while it runs.
  assign out_free  = !out_valid_r || out_tready;
  assign in_tready = !emit_busy && (!out_valid_r || !may_result);
  assign in_fire   = in_tvalid & in_tready;

  tfr_byte_parser #(
    .PAYLOAD_BYTES (PAYLOAD_BYTES)
  ) u_parser (
    .clk         (clk),
    .rst_n       (rst_n),
    .sync_first  (sync_first_r),
    .sync_second (sync_second_r),
    .in_fire     (in_fire),
    .in_byte     (in_tdata),
    .may_result  (may_result),
    .res         (prs_res),
    .wr          (mem_wr),
    .emit_start  (emit_start)
  );

  tfr_field_emit #(
    .PAYLOAD_BYTES (PAYLOAD_BYTES)
  ) u_emit (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr       (mem_wr),
    .start    (emit_start),
    .out_free (out_free),
    .busy     (emit_busy),
    .res      (emit_res)
  );

  // Output register. The parser only produces a beat when the register is
  // empty, and never while the sequencer runs, so the two sources never meet.
  always_comb begin
    out_valid_nxt = out_valid_r && !out_tready;
    out_kind_nxt  = out_kind_r;
    out_idx_nxt   = out_idx_r;
    out_value_nxt = out_value_r;
    out_last_nxt  = out_last_r;
    if (prs_res.valid) begin
      out_valid_nxt = 1'b1;
      out_kind_nxt  = prs_res.kind;
      out_idx_nxt   = prs_res.idx;
      out_value_nxt = {56'd0, prs_res.value};
      out_last_nxt  = prs_res.last;
    end else if (emit_res.valid) begin
      out_valid_nxt = 1'b1;
      out_kind_nxt  = emit_res.kind;
      out_idx_nxt   = emit_res.idx;
      out_value_nxt = emit_res.value;
      out_last_nxt  = emit_res.last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sync_first_r  <= 8'hAA;
      sync_second_r <= 8'h55;
      out_valid_r   <= 1'b0;
    end else begin
      sync_first_r  <= sync_first_nxt;
      sync_second_r <= sync_second_nxt;
      out_valid_r   <= out_valid_nxt;
    end
    out_kind_r  <= out_kind_nxt;
    out_idx_r   <= out_idx_nxt;
    out_value_r <= out_value_nxt;
    out_last_r  <= out_last_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_value_r, out_idx_r, out_kind_r};
  assign out_tlast  = out_last_r;

endmodule
`default_nettype wire
